// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared property shapes for the encoder speed pid rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ESPID_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// next-cycle implication, disabled during reset
`define ESPID_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// ===== rtl/espid_pkg.sv =====
// ----------------------------------------------------------------------------
// espid_pkg
// widths, codes and control types of the encoder speed pid controller
// ----------------------------------------------------------------------------
package espid_pkg;

   localparam int MOTOR_COUNT  = 4;
   localparam int IDX_W        = 2;
   localparam int GAIN_W       = 16;
   localparam int SCALE_W      = 16;
   localparam int COUNT_W      = 16;
   localparam int MAG_W        = 16;
   localparam int TARGET_W     = 24;
   localparam int SPEED_W      = 24;
   localparam int SPEED_FRAC   = 8;
   localparam int ERR_W        = 25;
   localparam int DIFF_W       = 26;
   localparam int SUM_W        = 40;
   localparam int SUM_LO_W     = 24;
   localparam int SUM_HI_W     = SUM_W - SUM_LO_W;
   localparam int MUL_A_W      = 17;
   localparam int MUL_B_W      = 27;
   localparam int PROD_W       = MUL_A_W + MUL_B_W;
   localparam int ACC_W        = 60;
   localparam int OUT_SHIFT    = 16;
   localparam int PWM_W        = 16;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 16;

   localparam logic [GAIN_W-1:0]  GAIN_P_RESET      = 16'd17920;
   localparam logic [GAIN_W-1:0]  GAIN_I_RESET      = 16'd1792;
   localparam logic [GAIN_W-1:0]  GAIN_D_RESET      = 16'd512;
   localparam logic [SCALE_W-1:0] SCALE_ZERO_RESET  = 16'd14826;
   localparam logic [SCALE_W-1:0] SCALE_OTHER_RESET = 16'd3707;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic [PWM_W-1:0]        PWM_MAX = {PWM_W{1'b1}};

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GAIN_P  = 3'd0,
      CSR_GAIN_I  = 3'd1,
      CSR_GAIN_D  = 3'd2,
      CSR_SCALE_0 = 3'd3,
      CSR_SCALE_1 = 3'd4,
      CSR_SCALE_2 = 3'd5,
      CSR_SCALE_3 = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0]                   gain_p;
      logic [GAIN_W-1:0]                   gain_i;
      logic [GAIN_W-1:0]                   gain_d;
      logic [MOTOR_COUNT-1:0][SCALE_W-1:0] scale;
   } csr_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MAG,
      S_ERR,
      S_MUL_P,
      S_MUL_D,
      S_MUL_ILO,
      S_MUL_IHI,
      S_ACC,
      S_OUT
   } state_type;

   typedef enum logic [2:0] {
      MUL_MAG_SCALE,
      MUL_P_ERR,
      MUL_D_DIFF,
      MUL_I_LO,
      MUL_I_HI
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_ADD_HI
   } acc_op_type;

   typedef struct packed {
      logic        load_in;
      mul_sel_type mul_sel;
      logic        update_state;
      acc_op_type  acc_op;
      logic        load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } ctrl_status_type;

endpackage

// ===== rtl/espid_req_if.sv =====
// ----------------------------------------------------------------------------
// espid_req_if
// control tick channel: valid/ready with the tick payload
// ----------------------------------------------------------------------------
interface espid_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [espid_pkg::IDX_W-1:0]             motor_index;
   logic signed [espid_pkg::COUNT_W-1:0]    encoder_count;
   logic signed [espid_pkg::TARGET_W-1:0]   target_speed;
   logic                                    force_stop;

   modport source (
      output valid, motor_index, encoder_count, target_speed, force_stop,
      input  ready
   );

   modport sink (
      input  valid, motor_index, encoder_count, target_speed, force_stop,
      output ready
   );
endinterface

// ===== rtl/espid_rsp_if.sv =====
// ----------------------------------------------------------------------------
// espid_rsp_if
// pwm result channel: valid/ready with motor index and duty
// ----------------------------------------------------------------------------
interface espid_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [espid_pkg::IDX_W-1:0]  motor_out_index;
   logic [espid_pkg::PWM_W-1:0]  pwm_duty;

   modport source (
      output valid, motor_out_index, pwm_duty,
      input  ready
   );

   modport sink (
      input  valid, motor_out_index, pwm_duty,
      output ready
   );
endinterface

// ===== rtl/espid_csr.sv =====
// ----------------------------------------------------------------------------
// espid_csr
// gain and scale registers behind the write-only config port
// ----------------------------------------------------------------------------
module espid_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [espid_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [espid_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output espid_pkg::csr_type                 csr
);

   espid_pkg::csr_type csr_ff;
   espid_pkg::csr_type csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         unique case (espid_pkg::csr_index_type'(csr_index))
            espid_pkg::CSR_GAIN_P:  csr_in.gain_p   = csr_write_data;
            espid_pkg::CSR_GAIN_I:  csr_in.gain_i   = csr_write_data;
            espid_pkg::CSR_GAIN_D:  csr_in.gain_d   = csr_write_data;
            espid_pkg::CSR_SCALE_0: csr_in.scale[0] = csr_write_data;
            espid_pkg::CSR_SCALE_1: csr_in.scale[1] = csr_write_data;
            espid_pkg::CSR_SCALE_2: csr_in.scale[2] = csr_write_data;
            espid_pkg::CSR_SCALE_3: csr_in.scale[3] = csr_write_data;
            default: begin
               // unused index, write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.gain_p   <= espid_pkg::GAIN_P_RESET;
         csr_ff.gain_i   <= espid_pkg::GAIN_I_RESET;
         csr_ff.gain_d   <= espid_pkg::GAIN_D_RESET;
         csr_ff.scale[0] <= espid_pkg::SCALE_ZERO_RESET;
         csr_ff.scale[1] <= espid_pkg::SCALE_OTHER_RESET;
         csr_ff.scale[2] <= espid_pkg::SCALE_OTHER_RESET;
         csr_ff.scale[3] <= espid_pkg::SCALE_OTHER_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr = csr_ff;

endmodule

// ===== rtl/espid_ctrl.sv =====
// ----------------------------------------------------------------------------
// espid_ctrl
// sequencer: steps one tick through speed, error and the shared multiplier
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module espid_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  espid_pkg::ctrl_status_type  status,
   output espid_pkg::ctrl_cmd_type     cmd
);

   espid_pkg::state_type state_ff;
   espid_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= espid_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in         = state_ff;
      req_ready        = 1'b0;
      cmd.load_in      = 1'b0;
      cmd.mul_sel      = espid_pkg::MUL_MAG_SCALE;
      cmd.update_state = 1'b0;
      cmd.acc_op       = espid_pkg::ACC_HOLD;
      cmd.load_out     = 1'b0;
      unique case (state_ff)
         espid_pkg::S_IDLE: begin
            req_ready   = 1'b1;
            cmd.load_in = req_valid;
            if (req_valid) begin
               state_in = espid_pkg::S_MAG;
            end
         end
         espid_pkg::S_MAG: begin
            cmd.mul_sel = espid_pkg::MUL_MAG_SCALE;
            state_in    = espid_pkg::S_ERR;
         end
         espid_pkg::S_ERR: begin
            cmd.update_state = 1'b1;
            state_in         = espid_pkg::S_MUL_P;
         end
         espid_pkg::S_MUL_P: begin
            cmd.mul_sel = espid_pkg::MUL_P_ERR;
            state_in    = espid_pkg::S_MUL_D;
         end
         espid_pkg::S_MUL_D: begin
            cmd.mul_sel = espid_pkg::MUL_D_DIFF;
            cmd.acc_op  = espid_pkg::ACC_LOAD;
            state_in    = espid_pkg::S_MUL_ILO;
         end
         espid_pkg::S_MUL_ILO: begin
            cmd.mul_sel = espid_pkg::MUL_I_LO;
            cmd.acc_op  = espid_pkg::ACC_ADD;
            state_in    = espid_pkg::S_MUL_IHI;
         end
         espid_pkg::S_MUL_IHI: begin
            cmd.mul_sel = espid_pkg::MUL_I_HI;
            cmd.acc_op  = espid_pkg::ACC_ADD;
            state_in    = espid_pkg::S_ACC;
         end
         espid_pkg::S_ACC: begin
            cmd.acc_op = espid_pkg::ACC_ADD_HI;
            state_in   = espid_pkg::S_OUT;
         end
         espid_pkg::S_OUT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = espid_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = espid_pkg::S_IDLE;
         end
      endcase
   end

   `ESPID_ASSERT_NEXT(a_accept_starts_tick, clock, reset, req_valid && req_ready, state_ff == espid_pkg::S_MAG)
   `ESPID_ASSERT_IMPLIES(a_idle_leaves_state_alone, clock, reset, req_ready, !cmd.update_state && cmd.acc_op == espid_pkg::ACC_HOLD)

endmodule

// ===== rtl/espid_dp.sv =====
// ----------------------------------------------------------------------------
// espid_dp
// datapath: per-motor state, shared multiplier, accumulator, result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module espid_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  espid_pkg::ctrl_cmd_type                cmd,
   output espid_pkg::ctrl_status_type             status,
   input  espid_pkg::csr_type                     csr,
   input  logic [espid_pkg::IDX_W-1:0]            req_motor_index,
   input  logic signed [espid_pkg::COUNT_W-1:0]   req_encoder_count,
   input  logic signed [espid_pkg::TARGET_W-1:0]  req_target_speed,
   input  logic                                   req_force_stop,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [espid_pkg::IDX_W-1:0]            rsp_motor_out_index,
   output logic [espid_pkg::PWM_W-1:0]            rsp_pwm_duty
);

   // per-motor controller state
   logic signed [espid_pkg::SUM_W-1:0] error_sum_ff [espid_pkg::MOTOR_COUNT];
   logic signed [espid_pkg::ERR_W-1:0] prev_err_ff  [espid_pkg::MOTOR_COUNT];

   // captured tick
   logic [espid_pkg::IDX_W-1:0]           idx_ff;
   logic [espid_pkg::MAG_W-1:0]           mag_ff;
   logic [espid_pkg::MAG_W-1:0]           mag_in;
   logic [espid_pkg::SCALE_W-1:0]         scale_ff;
   logic signed [espid_pkg::TARGET_W-1:0] target_ff;
   logic                                  stop_ff;

   // error stage
   logic [espid_pkg::SPEED_W-1:0]         speed;
   logic signed [espid_pkg::ERR_W-1:0]    err_ff, err_in;
   logic signed [espid_pkg::DIFF_W-1:0]   diff_ff, diff_in;
   logic signed [espid_pkg::SUM_W:0]      sum_wide;
   logic signed [espid_pkg::SUM_W-1:0]    sum_ff, sum_in;

   // shared multiplier and accumulator
   logic signed [espid_pkg::MUL_A_W-1:0]  mul_a;
   logic signed [espid_pkg::MUL_B_W-1:0]  mul_b;
   logic signed [espid_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic signed [espid_pkg::ACC_W-1:0]    prod_ext;
   logic signed [espid_pkg::ACC_W-1:0]    acc_ff, acc_in;

   // result register
   logic                                  rsp_valid_ff;
   logic [espid_pkg::IDX_W-1:0]           rsp_idx_ff;
   logic [espid_pkg::PWM_W-1:0]           rsp_pwm_ff, pwm_in;

   assign mag_in = req_encoder_count[espid_pkg::COUNT_W-1]
                 ? (~req_encoder_count + espid_pkg::MAG_W'(1))
                 : req_encoder_count;

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         idx_ff    <= req_motor_index;
         mag_ff    <= mag_in;
         scale_ff  <= csr.scale[req_motor_index];
         target_ff <= req_target_speed;
         stop_ff   <= req_force_stop;
      end
   end

   // speed is the Q.8 magnitude, forced to zero on stop
   assign speed = stop_ff ? '0
                : prod_ff[espid_pkg::SPEED_W+espid_pkg::SPEED_FRAC-1:espid_pkg::SPEED_FRAC];

   always_comb begin
      err_in   = $signed({target_ff[espid_pkg::TARGET_W-1], target_ff})
               - $signed({1'b0, speed});
      diff_in  = $signed({err_in[espid_pkg::ERR_W-1], err_in})
               - $signed({prev_err_ff[idx_ff][espid_pkg::ERR_W-1], prev_err_ff[idx_ff]});
      sum_wide = $signed({error_sum_ff[idx_ff][espid_pkg::SUM_W-1], error_sum_ff[idx_ff]})
               + $signed({{(espid_pkg::SUM_W+1-espid_pkg::ERR_W){err_in[espid_pkg::ERR_W-1]}},
                          err_in});
      // top two bits disagree: integral ran past its 40-bit range
      if (sum_wide[espid_pkg::SUM_W] != sum_wide[espid_pkg::SUM_W-1]) begin
         sum_in = sum_wide[espid_pkg::SUM_W] ? espid_pkg::SUM_MIN : espid_pkg::SUM_MAX;
      end else begin
         sum_in = sum_wide[espid_pkg::SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < espid_pkg::MOTOR_COUNT; i++) begin
            error_sum_ff[i] <= '0;
            prev_err_ff[i]  <= '0;
         end
      end else if (cmd.update_state) begin
         error_sum_ff[idx_ff] <= sum_in;
         prev_err_ff[idx_ff]  <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update_state) begin
         err_ff  <= err_in;
         diff_ff <= diff_in;
         sum_ff  <= sum_in;
      end
   end

   // operand select: gains and scale are unsigned, zero-extended by one bit
   always_comb begin
      mul_a = $signed({1'b0, scale_ff});
      mul_b = $signed({{(espid_pkg::MUL_B_W-espid_pkg::MAG_W){1'b0}}, mag_ff});
      case (cmd.mul_sel)
         espid_pkg::MUL_MAG_SCALE: begin
            mul_a = $signed({1'b0, scale_ff});
            mul_b = $signed({{(espid_pkg::MUL_B_W-espid_pkg::MAG_W){1'b0}}, mag_ff});
         end
         espid_pkg::MUL_P_ERR: begin
            mul_a = $signed({1'b0, csr.gain_p});
            mul_b = $signed({{(espid_pkg::MUL_B_W-espid_pkg::ERR_W){err_ff[espid_pkg::ERR_W-1]}},
                             err_ff});
         end
         espid_pkg::MUL_D_DIFF: begin
            mul_a = $signed({1'b0, csr.gain_d});
            mul_b = $signed({{(espid_pkg::MUL_B_W-espid_pkg::DIFF_W){diff_ff[espid_pkg::DIFF_W-1]}},
                             diff_ff});
         end
         espid_pkg::MUL_I_LO: begin
            mul_a = $signed({1'b0, csr.gain_i});
            mul_b = $signed({{(espid_pkg::MUL_B_W-espid_pkg::SUM_LO_W){1'b0}},
                             sum_ff[espid_pkg::SUM_LO_W-1:0]});
         end
         espid_pkg::MUL_I_HI: begin
            mul_a = $signed({1'b0, csr.gain_i});
            mul_b = $signed({{(espid_pkg::MUL_B_W-espid_pkg::SUM_HI_W){sum_ff[espid_pkg::SUM_W-1]}},
                             sum_ff[espid_pkg::SUM_W-1:espid_pkg::SUM_LO_W]});
         end
         default: begin
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod_ext = {{(espid_pkg::ACC_W-espid_pkg::PROD_W){prod_ff[espid_pkg::PROD_W-1]}},
                      prod_ff};

   always_comb begin
      acc_in = acc_ff;
      case (cmd.acc_op)
         espid_pkg::ACC_LOAD:   acc_in = prod_ext;
         espid_pkg::ACC_ADD:    acc_in = acc_ff + prod_ext;
         espid_pkg::ACC_ADD_HI: acc_in = acc_ff + (prod_ext <<< espid_pkg::SUM_LO_W);
         default:               acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // negative drive gives zero, anything past 16 bits after the shift saturates
   always_comb begin
      if (acc_ff[espid_pkg::ACC_W-1]) begin
         pwm_in = '0;
      end else if (|acc_ff[espid_pkg::ACC_W-2:espid_pkg::OUT_SHIFT+espid_pkg::PWM_W]) begin
         pwm_in = espid_pkg::PWM_MAX;
      end else begin
         pwm_in = acc_ff[espid_pkg::OUT_SHIFT+espid_pkg::PWM_W-1:espid_pkg::OUT_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_idx_ff <= idx_ff;
         rsp_pwm_ff <= pwm_in;
      end
   end

   assign status.out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_motor_out_index = rsp_idx_ff;
   assign rsp_pwm_duty        = rsp_pwm_ff;

   `ESPID_ASSERT_IMPLIES(a_load_out_slot_free, clock, reset, cmd.load_out, !rsp_valid_ff || rsp_ready)
   `ESPID_ASSERT_NEXT(a_state_written_back, clock, reset, cmd.update_state, error_sum_ff[idx_ff] == sum_ff && prev_err_ff[idx_ff] == err_ff)

endmodule

// ===== rtl/encoder_speed_pid_top.sv =====
// ----------------------------------------------------------------------------
// encoder_speed_pid_top
// four-motor pid speed controller driven by encoder counts
// ----------------------------------------------------------------------------
// Each req transaction is one control tick for one motor: the encoder count
// is scaled to a Q.8 speed (magnitude, zero when force_stop is set), the
// error against the target is added into a saturating 40-bit integral, and
// Kp*e + Ki*I + Kd*(e - last error) is shifted right by 16 and clamped to
// 0..65535 as the pwm duty of one rsp transaction. Ticks are handled one at
// a time. A tick steps through the scale product, the error, the Kp and Kd
// products, the Ki products on the low and high halves of the integral, the
// last accumulator add and the result load; all five products share the
// single 17x27 multiplier. The next tick is accepted the cycle after its
// predecessor's result is loaded, and a result waiting on rsp does not block
// the following tick until its own result is ready. The user must write
// gains and scales through the csr port only while no tick is in flight;
// the block itself does not enforce this. Index 7 is ignored.
module encoder_speed_pid_top (
   input  logic                               clock,
   input  logic                               reset,
   espid_req_if.sink                          req_if,
   espid_rsp_if.source                        rsp_if,
   input  logic                               csr_write_enable,
   input  logic [espid_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [espid_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   // configuration registers
   espid_pkg::csr_type         csr;

   // controller to datapath commands and back
   espid_pkg::ctrl_cmd_type    cmd;
   espid_pkg::ctrl_status_type status;

   espid_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .csr              (csr)
   );

   // sequencer owns the req handshake
   espid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath owns the rsp output register
   espid_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr                 (csr),
      .req_motor_index     (req_if.motor_index),
      .req_encoder_count   (req_if.encoder_count),
      .req_target_speed    (req_if.target_speed),
      .req_force_stop      (req_if.force_stop),
      .rsp_valid           (rsp_if.valid),
      .rsp_ready           (rsp_if.ready),
      .rsp_motor_out_index (rsp_if.motor_out_index),
      .rsp_pwm_duty        (rsp_if.pwm_duty)
   );

endmodule

// ===== sim/tb_encoder_speed_pid_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_encoder_speed_pid_top
// self-checking bench for the four-motor encoder speed pid controller
// ----------------------------------------------------------------------------
// A short table of directed ticks runs first on the reset gains. After it come
// phases of random ticks, each under its own gains and scales, written through
// the csr port while the block is idle. The soak phase drives two motors back
// to back with the largest positive and the largest negative error. Every
// accepted tick goes through a behavioral copy of the controller. Each rsp
// transaction is compared with the oldest pending result. The sender works in
// bursts, and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb_encoder_speed_pid_top;

   localparam longint CYCLE_LIMIT   = 64'd8_000_000;
   localparam int     SETTLE_CYCLES = 16;
   localparam int     RANDOM_PHASES = 6;
   localparam int     PHASE_TICKS   = 180;
   localparam int     SOAK_TICKS    = 30;

   // index past the register list, must be ignored by the block
   localparam logic [espid_pkg::CSR_INDEX_W-1:0] CSR_SPARE = 3'd7;

   typedef struct packed {
      logic [espid_pkg::IDX_W-1:0]    motor;
      logic [espid_pkg::COUNT_W-1:0]  count;
      logic [espid_pkg::TARGET_W-1:0] target;
      logic                           stop;
   } tick_type;

   typedef struct packed {
      logic [espid_pkg::IDX_W-1:0] motor;
      logic [espid_pkg::PWM_W-1:0] duty;
   } pwm_result_type;

   // fixed set: duty typed in below, otherwise taken from the predictor
   typedef struct packed {
      tick_type                    tick;
      logic                        fixed;
      logic [espid_pkg::PWM_W-1:0] duty;
   } directed_row_type;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_LIGHT,
      RX_HEAVY,
      RX_SQUARE
   } rx_mode_type;

   logic                              clock;
   logic                              reset;
   logic                              csr_write_enable;
   logic [espid_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [espid_pkg::CSR_DATA_W-1:0]  csr_write_data;

   espid_req_if req_bus ();
   espid_rsp_if rsp_bus ();

   encoder_speed_pid_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_bus),
      .rsp_if           (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // predictor state: register copy plus per-motor integral and last error
   espid_pkg::csr_type csr_mirror;
   longint             motor_integral [espid_pkg::MOTOR_COUNT];
   longint             motor_last_error [espid_pkg::MOTOR_COUNT];
   pwm_result_type     pending_pwm [$];

   int             mismatch_count = 0;
   longint         cycle_count    = 0;
   int             burst_left     = 0;
   bit             fast_drain     = 1'b0;
   rx_mode_type    rx_mode        = RX_OPEN;
   int             rx_mode_left   = 0;
   pwm_result_type rx_want;

   // directed ticks on the reset gains, motors start from a zero integral
   directed_row_type directed_rows [15] = '{
      // all zero: no error, no drive
      '{'{2'd0, 16'h0000, 24'h000000, 1'b0}, 1'b1, 16'd0},
      // most negative target: negative drive gives zero
      '{'{2'd1, 16'h0000, 24'h800000, 1'b0}, 1'b1, 16'd0},
      // most positive target with no motion: drive clamps high
      '{'{2'd2, 16'h0000, 24'h7FFFFF, 1'b0}, 1'b1, espid_pkg::PWM_MAX},
      // most negative count but stopped: speed forced to zero
      '{'{2'd3, 16'h8000, 24'h000000, 1'b1}, 1'b1, 16'd0},
      // most negative count moving, zero target: negative drive
      '{'{2'd3, 16'h8000, 24'h000000, 1'b0}, 1'b1, 16'd0},
      '{'{2'd3, 16'h7FFF, 24'h7FFFFF, 1'b0}, 1'b0, 16'd0},
      // most positive count, zero target: negative drive
      '{'{2'd0, 16'h7FFF, 24'h000000, 1'b0}, 1'b1, 16'd0},
      '{'{2'd0, 16'hFFFF, 24'h000000, 1'b1}, 1'b0, 16'd0},
      '{'{2'd1, 16'h000A, 24'h0000C8, 1'b0}, 1'b0, 16'd0},
      '{'{2'd1, 16'hFFF6, 24'h0000C8, 1'b0}, 1'b0, 16'd0},
      '{'{2'd2, 16'h0000, 24'h000000, 1'b1}, 1'b0, 16'd0},
      '{'{2'd0, 16'h8000, 24'h800000, 1'b1}, 1'b0, 16'd0},
      '{'{2'd1, 16'h0001, 24'h000001, 1'b0}, 1'b0, 16'd0},
      '{'{2'd2, 16'h8000, 24'h7FFFFF, 1'b0}, 1'b0, 16'd0},
      '{'{2'd3, 16'h0000, 24'hFFFFFF, 1'b0}, 1'b0, 16'd0}
   };

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit, sized well above the slowest legal run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** encoder_speed_pid_top: FAILED **");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // pid step for one tick: updates the motor state, returns the pwm result
   function automatic pwm_result_type predict_duty(input tick_type t);
      longint         cnt, tgt, mag, scl, speed, err, sum, acc;
      longint         kp, ki, kd, sum_hi, sum_lo;
      pwm_result_type res;
      cnt    = $signed(t.count);
      tgt    = $signed(t.target);
      kp     = csr_mirror.gain_p;
      ki     = csr_mirror.gain_i;
      kd     = csr_mirror.gain_d;
      scl    = csr_mirror.scale[t.motor];
      sum_hi = espid_pkg::SUM_MAX;
      sum_lo = espid_pkg::SUM_MIN;
      mag    = (cnt < 0) ? -cnt : cnt;
      speed  = t.stop ? 64'sd0 : ((mag * scl) >>> espid_pkg::SPEED_FRAC);
      err    = tgt - speed;
      sum    = motor_integral[t.motor] + err;
      if (sum > sum_hi) sum = sum_hi;
      if (sum < sum_lo) sum = sum_lo;
      acc = kp * err + ki * sum + kd * (err - motor_last_error[t.motor]);
      motor_integral[t.motor]   = sum;
      motor_last_error[t.motor] = err;
      res.motor = t.motor;
      if (acc < 0)
         res.duty = '0;
      else if ((acc >>> espid_pkg::OUT_SHIFT) > longint'(espid_pkg::PWM_MAX))
         res.duty = espid_pkg::PWM_MAX;
      else
         res.duty = espid_pkg::PWM_W'(acc >>> espid_pkg::OUT_SHIFT);
      return res;
   endfunction

   // random tick: small or full-range counts and targets, sometimes extremes
   function automatic tick_type random_tick();
      tick_type t;
      int       pick;
      t.motor = espid_pkg::IDX_W'($urandom_range(0, espid_pkg::MOTOR_COUNT - 1));
      pick = $urandom_range(0, 9);
      if (pick < 4)
         t.count = espid_pkg::COUNT_W'($urandom_range(0, 32) - 16);
      else if (pick < 8)
         t.count = espid_pkg::COUNT_W'($urandom);
      else
         case ($urandom_range(0, 3))
            0:       t.count = 16'h8000;
            1:       t.count = 16'h7FFF;
            2:       t.count = 16'h0000;
            default: t.count = 16'hFFFF;
         endcase
      pick = $urandom_range(0, 9);
      if (pick < 4)
         t.target = espid_pkg::TARGET_W'($urandom_range(0, 4096) - 2048);
      else if (pick < 8)
         t.target = espid_pkg::TARGET_W'($urandom);
      else
         case ($urandom_range(0, 3))
            0:       t.target = 24'h800000;
            1:       t.target = 24'h7FFFFF;
            2:       t.target = 24'h000000;
            default: t.target = 24'hFFFFFF;
         endcase
      t.stop = ($urandom_range(0, 7) == 0);
      return t;
   endfunction

   // one req transaction; paced ticks come in bursts with idle gaps between
   task automatic send_tick(input tick_type t, input bit paced);
      int gap;
      if (paced) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 6);
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
         end
         burst_left--;
      end
      req_bus.valid         <= 1'b1;
      req_bus.motor_index   <= t.motor;
      req_bus.encoder_count <= t.count;
      req_bus.target_speed  <= t.target;
      req_bus.force_stop    <= t.stop;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      pending_pwm.push_back(predict_duty(t));
   endtask

   // stop sending and wait for every pending pwm result
   task automatic drain_pending();
      req_bus.valid <= 1'b0;
      while (pending_pwm.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_reg(input logic [espid_pkg::CSR_INDEX_W-1:0] idx,
                          input logic [espid_pkg::CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   // writes every register, plus the undecoded index, back to back
   task automatic write_settings(input espid_pkg::csr_type cfg);
      put_reg(CSR_SPARE,              espid_pkg::CSR_DATA_W'($urandom));
      put_reg(espid_pkg::CSR_GAIN_P,  cfg.gain_p);
      put_reg(espid_pkg::CSR_GAIN_I,  cfg.gain_i);
      put_reg(espid_pkg::CSR_GAIN_D,  cfg.gain_d);
      put_reg(espid_pkg::CSR_SCALE_0, cfg.scale[0]);
      put_reg(espid_pkg::CSR_SCALE_1, cfg.scale[1]);
      put_reg(espid_pkg::CSR_SCALE_2, cfg.scale[2]);
      put_reg(espid_pkg::CSR_SCALE_3, cfg.scale[3]);
      csr_write_enable <= 1'b0;
      csr_mirror = cfg;
   endtask

   // pwm receiver: checks each rsp transaction and drives the stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (pending_pwm.size() == 0) begin
               report_mismatch("pwm transaction with nothing pending", rsp_bus.pwm_duty, -1);
            end else begin
               rx_want = pending_pwm.pop_front();
               if (rsp_bus.motor_out_index !== rx_want.motor)
                  report_mismatch("motor_out_index", rsp_bus.motor_out_index, rx_want.motor);
               if (rsp_bus.pwm_duty !== rx_want.duty)
                  report_mismatch("pwm_duty", rsp_bus.pwm_duty, rx_want.duty);
            end
         end
         // stall pattern is picked anew at random when its run ends
         if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_type'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(16, 200);
         end
         rx_mode_left--;
         if (fast_drain)
            rsp_bus.ready <= 1'b1;
         else
            case (rx_mode)
               RX_OPEN:  rsp_bus.ready <= 1'b1;
               RX_LIGHT: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               RX_HEAVY: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default:  rsp_bus.ready <= cycle_count[3];
            endcase
      end
   end

   initial begin
      espid_pkg::csr_type cfg;
      tick_type           t;
      int                 phase, n, m;

      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.motor_index   = '0;
      req_bus.encoder_count = '0;
      req_bus.target_speed  = '0;
      req_bus.force_stop    = 1'b0;
      rsp_bus.ready         = 1'b0;
      csr_write_enable      = 1'b0;
      csr_index             = '0;
      csr_write_data        = '0;

      // block comes out of reset with default gains and zero motor state
      csr_mirror.gain_p   = espid_pkg::GAIN_P_RESET;
      csr_mirror.gain_i   = espid_pkg::GAIN_I_RESET;
      csr_mirror.gain_d   = espid_pkg::GAIN_D_RESET;
      csr_mirror.scale[0] = espid_pkg::SCALE_ZERO_RESET;
      for (m = 1; m < espid_pkg::MOTOR_COUNT; m++)
         csr_mirror.scale[m] = espid_pkg::SCALE_OTHER_RESET;
      for (m = 0; m < espid_pkg::MOTOR_COUNT; m++) begin
         motor_integral[m]   = 0;
         motor_last_error[m] = 0;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table on the reset gains
      foreach (directed_rows[i]) begin
         send_tick(directed_rows[i].tick, 1'b1);
         if (directed_rows[i].fixed)
            pending_pwm[$].duty = directed_rows[i].duty;
      end
      drain_pending();

      // random phases, each under its own register setting
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               // everything at maximum
               cfg.gain_p = espid_pkg::PWM_MAX;
               cfg.gain_i = espid_pkg::PWM_MAX;
               cfg.gain_d = espid_pkg::PWM_MAX;
               for (m = 0; m < espid_pkg::MOTOR_COUNT; m++) cfg.scale[m] = espid_pkg::PWM_MAX;
            end
            1: begin
               // everything zero
               cfg = '0;
            end
            2: begin
               // reset values written back explicitly
               cfg.gain_p   = espid_pkg::GAIN_P_RESET;
               cfg.gain_i   = espid_pkg::GAIN_I_RESET;
               cfg.gain_d   = espid_pkg::GAIN_D_RESET;
               cfg.scale[0] = espid_pkg::SCALE_ZERO_RESET;
               for (m = 1; m < espid_pkg::MOTOR_COUNT; m++)
                  cfg.scale[m] = espid_pkg::SCALE_OTHER_RESET;
            end
            3: begin
               // small gains keep the duty inside its range more often
               cfg.gain_p = espid_pkg::GAIN_W'($urandom_range(0, 1023));
               cfg.gain_i = espid_pkg::GAIN_W'($urandom_range(0, 63));
               cfg.gain_d = espid_pkg::GAIN_W'($urandom_range(0, 1023));
               for (m = 0; m < espid_pkg::MOTOR_COUNT; m++)
                  cfg.scale[m] = espid_pkg::SCALE_W'($urandom);
            end
            4: begin
               cfg.gain_p = espid_pkg::GAIN_W'($urandom);
               cfg.gain_i = espid_pkg::GAIN_W'($urandom);
               cfg.gain_d = espid_pkg::GAIN_W'($urandom);
               for (m = 0; m < espid_pkg::MOTOR_COUNT; m++)
                  cfg.scale[m] = espid_pkg::SCALE_W'($urandom);
            end
            default: begin
               // no integral term, scales at the extremes or random
               cfg.gain_p = espid_pkg::GAIN_W'($urandom_range(0, 511));
               cfg.gain_i = '0;
               cfg.gain_d = espid_pkg::GAIN_W'($urandom);
               for (m = 0; m < espid_pkg::MOTOR_COUNT; m++)
                  case ($urandom_range(0, 2))
                     0:       cfg.scale[m] = '0;
                     1:       cfg.scale[m] = espid_pkg::PWM_MAX;
                     default: cfg.scale[m] = espid_pkg::SCALE_W'($urandom);
                  endcase
            end
         endcase
         write_settings(cfg);
         for (n = 0; n < PHASE_TICKS; n++) begin
            // sender holds off mid phase until every result is back
            if (n == PHASE_TICKS / 2) drain_pending();
            send_tick(random_tick(), 1'b1);
         end
         drain_pending();
      end

      // back-to-back run: motor 2 with the largest positive error,
      // motor 3 with the largest negative one
      cfg.gain_p = 16'd256;
      cfg.gain_i = 16'd1;
      cfg.gain_d = '0;
      for (m = 0; m < espid_pkg::MOTOR_COUNT; m++) cfg.scale[m] = espid_pkg::SCALE_W'($urandom);
      cfg.scale[3] = espid_pkg::PWM_MAX;
      write_settings(cfg);
      fast_drain = 1'b1;
      for (n = 0; n < SOAK_TICKS; n++) begin
         if (n % 3 == 2)
            t = '{2'd3, 16'h8000, 24'h800000, 1'b0};
         else
            t = '{2'd2, 16'h0000, 24'h7FFFFF, 1'b1};
         send_tick(t, 1'b0);
      end
      drain_pending();
      fast_drain = 1'b0;

      // a few random ticks on the same two motors
      for (n = 0; n < 24; n++) begin
         t = random_tick();
         t.motor = espid_pkg::IDX_W'($urandom_range(2, 3));
         send_tick(t, 1'b1);
      end
      drain_pending();

      if (mismatch_count == 0)
         $display("** encoder_speed_pid_top: PASSED **");
      else
         $display("** encoder_speed_pid_top: FAILED **");
      $finish;
   end

endmodule
